### rtl/cbd_pkg.sv
// Shared types, constants and saturation helpers for the Chebyshev basis block.
`default_nettype none

package cbd_pkg;

  // Fraction bits of x, T_n and T'_n; the field widths below are fixed.
  localparam int FRAC_BITS   = 30;
  // Highest order the block ever produces.
  localparam int ORDER_LIMIT = 63;

  localparam int ORDER_W = 6;
  localparam int VALUE_W = 32;
  localparam int SLOPE_W = 48;

  localparam logic [ORDER_W-1:0] ORDER_LIMIT_V = ORDER_W'(ORDER_LIMIT);
  localparam logic [ORDER_W-1:0] MAX_ORDER_RST = 6'd16;

  localparam logic signed [VALUE_W-1:0] T_ONE = VALUE_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [SLOPE_W-1:0] D_ONE = SLOPE_W'(64'sd1 <<< FRAC_BITS);

  localparam logic signed [63:0] VAL_MAX64   = 64'sd2147483647;
  localparam logic signed [63:0] VAL_MIN64   = -64'sd2147483648;
  localparam logic signed [63:0] SLOPE_MAX64 = 64'sd140737488355327;
  localparam logic signed [63:0] SLOPE_MIN64 = -64'sd140737488355328;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SEED,
    ST_MUL_T,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_SLOPE
  } cbd_state_t;

  // Second multiplier operand: T_{n-1}, or the low or high part of D_{n-1}.
  typedef enum logic [1:0] {
    MSRC_T,
    MSRC_LO,
    MSRC_HI
  } cbd_msrc_t;

  typedef struct packed {
    logic               load;
    logic               seed;
    logic               mul_en;
    cbd_msrc_t          mul_src;
    logic               t_calc;
    logic               lo_keep;
    logic               s_calc;
    logic               d_calc;
    logic               emit;
    logic [ORDER_W-1:0] order;
    logic               last;
  } cbd_cmd_t;

  typedef struct packed {
    logic out_free;
  } cbd_sts_t;

  function automatic logic signed [VALUE_W-1:0] sat_val(input logic signed [63:0] v);
    logic signed [VALUE_W-1:0] r;
    if (v > VAL_MAX64) begin
      r = VAL_MAX64[VALUE_W-1:0];
    end else if (v < VAL_MIN64) begin
      r = VAL_MIN64[VALUE_W-1:0];
    end else begin
      r = v[VALUE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SLOPE_W-1:0] sat_slope(input logic signed [63:0] v);
    logic signed [SLOPE_W-1:0] r;
    if (v > SLOPE_MAX64) begin
      r = SLOPE_MAX64[SLOPE_W-1:0];
    end else if (v < SLOPE_MIN64) begin
      r = SLOPE_MIN64[SLOPE_W-1:0];
    end else begin
      r = v[SLOPE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/chebyshev_basis_with_derivative.sv
// Top level of the Chebyshev basis generator with derivative.
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid/in_ready    in_sample_pos (unsigned Q0.SAMPLE_BITS)
//   out_      output     out_valid/out_ready  out_order, out_basis_value, out_basis_slope,
//                                             out_last
//   cfg_      input      cfg_we               cfg_wdata (max_order)
//
// One sample produces max_order+1 results, orders 0 upward, with out_last on the final one.
// Order 0 is written in the write step that follows the input transfer, and order 1 in the
// write step after the seed step. Every higher order takes six steps: three on the single
// shared 32x32 multiplier (x*T, x*D low half, x*D high half), one to reassemble the slope
// product, one to add and saturate, and one to write the result.
// Reset is synchronous and active low; it returns the sequencer to idle, empties the result
// register and sets max_order to 16.
// A stalled result transfer holds the sequencer at its next write, and the next sample is
// taken as soon as the last result of a run has been written, even if it has not left yet.
`default_nettype none

module chebyshev_basis_with_derivative
  import cbd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic [SAMPLE_BITS-1:0]    in_sample_pos,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic [ORDER_W-1:0]        out_order,
  output      logic signed [VALUE_W-1:0] out_basis_value,
  output      logic signed [SLOPE_W-1:0] out_basis_slope,
  output      logic                      out_last,
  input  wire logic                      cfg_we,
  input  wire logic [ORDER_W-1:0]        cfg_wdata
);

  cbd_cmd_t cmd;
  cbd_sts_t sts;

  // The sequencer owns the order counter and the max_order setting.
  cbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds x, the two previous orders of T and D, and the result register.
  cbd_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_sample_pos   (in_sample_pos),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_order       (out_order),
    .out_basis_value (out_basis_value),
    .out_basis_slope (out_basis_slope),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

### rtl/cbd_ctrl.sv
// Sequencer for the Chebyshev recurrence: order counter, setting register and step control.
`default_nettype none

module cbd_ctrl
  import cbd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               cfg_we,
  input  wire logic [ORDER_W-1:0] cfg_wdata,
  input  wire cbd_sts_t           sts,
  output      cbd_cmd_t           cmd
);

  cbd_state_t         state_r, state_nxt;
  logic [ORDER_W-1:0] n_r;
  logic [ORDER_W-1:0] max_order_r;
  logic [ORDER_W-1:0] top;
  logic               is_last;
  logic               accept;

  assign top     = (max_order_r > ORDER_LIMIT_V) ? ORDER_LIMIT_V : max_order_r;
  assign is_last = (n_r == top);
  assign accept  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= '0;
      max_order_r <= MAX_ORDER_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        max_order_r <= cfg_wdata;
      end
      if (cmd.load) begin
        n_r <= '0;
      end else if (cmd.emit) begin
        n_r <= n_r + ORDER_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (sts.out_free) begin
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else if (n_r == '0) begin
            state_nxt = ST_SEED;
          end else begin
            state_nxt = ST_MUL_T;
          end
        end
      end
      ST_SEED:   state_nxt = ST_WRITE;
      ST_MUL_T:  state_nxt = ST_MUL_LO;
      ST_MUL_LO: state_nxt = ST_MUL_HI;
      ST_MUL_HI: state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_SLOPE;
      ST_SLOPE:  state_nxt = ST_WRITE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.mul_src = MSRC_T;
    cmd.order   = n_r;
    cmd.last    = is_last;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_WRITE:  cmd.emit = sts.out_free;
      ST_SEED:   cmd.seed = 1'b1;
      ST_MUL_T: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = MSRC_T;
      end
      ST_MUL_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = MSRC_LO;
        cmd.t_calc  = 1'b1;
      end
      ST_MUL_HI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = MSRC_HI;
        cmd.lo_keep = 1'b1;
      end
      ST_SUM:    cmd.s_calc = 1'b1;
      ST_SLOPE:  cmd.d_calc = 1'b1;
      default:   cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/cbd_dp.sv
// Datapath: x mapping, shared multiplier, recurrence registers and result register.
`default_nettype none

module cbd_dp
  import cbd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [SAMPLE_BITS-1:0]    in_sample_pos,
  input  wire cbd_cmd_t                  cmd,
  output      cbd_sts_t                  sts,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic [ORDER_W-1:0]        out_order,
  output      logic signed [VALUE_W-1:0] out_basis_value,
  output      logic signed [SLOPE_W-1:0] out_basis_slope,
  output      logic                      out_last
);

  localparam int XSHL = (FRAC_BITS + 1 >= SAMPLE_BITS) ? (FRAC_BITS + 1 - SAMPLE_BITS) : 0;
  localparam int XSHR = (FRAC_BITS + 1 >= SAMPLE_BITS) ? 0 : (SAMPLE_BITS - FRAC_BITS - 1);

  logic signed [VALUE_W-1:0] x_r, t_prev_r, t_cur_r, t_new_r;
  logic signed [SLOPE_W-1:0] d_prev_r, d_cur_r, d_new_r;
  logic signed [63:0]        p_r, lo_r, s_r;
  logic                      out_valid_r;
  logic [ORDER_W-1:0]        out_order_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic signed [SLOPE_W-1:0] out_slope_r;
  logic                      out_last_r;

  logic [63:0]               pos_w;
  logic [63:0]               x_full;
  logic signed [VALUE_W-1:0] mul_b;
  logic signed [63:0]        prod_w;
  logic signed [63:0]        t_sum;
  logic signed [79:0]        wide_sum;
  logic signed [79:0]        wide_sh;
  logic signed [63:0]        d_sum;

  // x = 2u - 1 in Q1.FRAC_BITS.
  assign pos_w  = 64'(in_sample_pos);
  assign x_full = ((pos_w << XSHL) >> XSHR) - 64'(T_ONE);

  always_comb begin
    unique case (cmd.mul_src)
      MSRC_T:  mul_b = t_cur_r;
      MSRC_LO: mul_b = $signed({16'd0, d_cur_r[15:0]});
      MSRC_HI: mul_b = d_cur_r[SLOPE_W-1:16];
      default: mul_b = t_cur_r;
    endcase
  end

  assign prod_w = 64'(x_r) * 64'(mul_b);

  // floor(2x T / 2^FRAC_BITS) is an arithmetic shift of the exact product.
  assign t_sum    = (p_r >>> (FRAC_BITS - 1)) - 64'(t_prev_r);
  // Reassemble x * D from its high and low partial products, then floor.
  assign wide_sum = ($signed({{16{p_r[63]}}, p_r}) <<< 16) + $signed({{16{lo_r[63]}}, lo_r});
  assign wide_sh  = wide_sum >>> (FRAC_BITS - 1);
  assign d_sum    = s_r + (64'(t_cur_r) <<< 1) - 64'(d_prev_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= x_full[VALUE_W-1:0];
      t_new_r <= T_ONE;
      d_new_r <= '0;
      t_cur_r <= '0;
      d_cur_r <= '0;
    end
    if (cmd.seed) begin
      t_new_r <= x_r;
      d_new_r <= D_ONE;
    end
    if (cmd.mul_en)  p_r     <= prod_w;
    if (cmd.t_calc)  t_new_r <= sat_val(t_sum);
    if (cmd.lo_keep) lo_r    <= p_r;
    if (cmd.s_calc)  s_r     <= wide_sh[63:0];
    if (cmd.d_calc)  d_new_r <= sat_slope(d_sum);
    if (cmd.emit) begin
      out_order_r <= cmd.order;
      out_value_r <= t_new_r;
      out_slope_r <= d_new_r;
      out_last_r  <= cmd.last;
      t_prev_r    <= t_cur_r;
      t_cur_r     <= t_new_r;
      d_prev_r    <= d_cur_r;
      d_cur_r     <= d_new_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_free    = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_order       = out_order_r;
  assign out_basis_value = out_value_r;
  assign out_basis_slope = out_slope_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

### rtl/cbd_checker.sv
// Port-level checker for the Chebyshev basis block, with its bind statement.
`default_nettype none

module cbd_checker
  import cbd_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [ORDER_W-1:0]        out_order,
  input wire logic signed [VALUE_W-1:0] out_basis_value,
  input wire logic signed [SLOPE_W-1:0] out_basis_slope,
  input wire logic                      out_last,
  input wire logic                      cfg_we,
  input wire logic [ORDER_W-1:0]        cfg_wdata
);

  logic [ORDER_W-1:0] cfg_r;
  logic [ORDER_W-1:0] exp_order_r;
  logic [ORDER_W-1:0] top;

  assign top = (cfg_r > ORDER_LIMIT_V) ? ORDER_LIMIT_V : cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= MAX_ORDER_RST;
      exp_order_r <= '0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        exp_order_r <= out_last ? '0 : (out_order + ORDER_W'(1));
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_order)
      && $stable(out_basis_value) && $stable(out_basis_slope))
    else $error("result changed while stalled");

  a_order_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_order == exp_order_r)
    else $error("result order out of sequence");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_last == (out_order == top))
    else $error("last flag does not match max_order");

  a_seed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_order == '0 |-> out_basis_value == T_ONE && out_basis_slope == '0)
    else $error("order zero result is not T0 = 1, D0 = 0");

endmodule

bind chebyshev_basis_with_derivative cbd_checker u_cbd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_order       (out_order),
  .out_basis_value (out_basis_value),
  .out_basis_slope (out_basis_slope),
  .out_last        (out_last),
  .cfg_we          (cfg_we),
  .cfg_wdata       (cfg_wdata)
);

`default_nettype wire

### tb/chebyshev_basis_with_derivative_test.sv
// Self-checking testbench for the Chebyshev basis generator with derivative.
`timescale 1ns / 100ps

module chebyshev_basis_with_derivative_test
  import cbd_pkg::*;
();

  // Fixed-point format of x, T_n and T'_n as the block defines it.
  localparam int FRAC = 30;
  localparam int POS_BITS = 16;
  localparam logic [ORDER_W-1:0] RESET_MAX_ORDER = 6'd16;
  localparam logic signed [63:0] FIX_ONE = 64'sd1 <<< FRAC;
  localparam logic signed [63:0] BASIS_HI = 64'sd2147483647;
  localparam logic signed [63:0] BASIS_LO = -64'sd2147483648;
  localparam logic signed [63:0] SLOPE_HI = 64'sd140737488355327;
  localparam logic signed [63:0] SLOPE_LO = -64'sd140737488355328;

  // Cycles with no transfer on either channel before the run is declared hung.
  // The slowest gap between two transfers is one order of the recurrence plus
  // a full receiver stall and a full sender gap, far below this.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet time after the last expected result: it is longer than a full run up
  // to order 63, so any stray result would show up well within this window.
  localparam int TAIL_CYCLES = 400;

  // One result of the recurrence: order, T_n, T'_n and the end-of-run flag.
  typedef struct {
    logic [ORDER_W-1:0]        order;
    logic signed [VALUE_W-1:0] value;
    logic signed [SLOPE_W-1:0] slope;
    logic                      last;
  } cheb_term_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [POS_BITS-1:0]       in_sample_pos;
  logic                      out_valid;
  logic                      out_ready;
  logic [ORDER_W-1:0]        out_order;
  logic signed [VALUE_W-1:0] out_basis_value;
  logic signed [SLOPE_W-1:0] out_basis_slope;
  logic                      out_last;
  logic                      cfg_we;
  logic [ORDER_W-1:0]        cfg_wdata;

  // Terms predicted for accepted samples, oldest first.
  cheb_term_t pending_terms[$];
  // Our own copy of the max_order register.
  logic [ORDER_W-1:0] max_order_copy;
  int mismatch_count = 0;
  int idle_cycles = 0;
  // Random idling on each side; cleared for stretches of back-to-back traffic.
  bit in_gaps_on = 1'b1;
  bit out_stalls_on = 1'b1;

  chebyshev_basis_with_derivative u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_pos   (in_sample_pos),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_order       (out_order),
    .out_basis_value (out_basis_value),
    .out_basis_slope (out_basis_slope),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Saturate a wide intermediate to a signed field range.
  function automatic logic signed [63:0] clamp_range(input logic signed [63:0] v,
                                                     input logic signed [63:0] lo,
                                                     input logic signed [63:0] hi);
    if (v < lo) begin
      return lo;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // floor(2 * x * v / 2^FRAC): the full product is formed at 128 bits, so the
  // arithmetic shift gives exact rounding toward minus infinity.
  function automatic logic signed [63:0] twice_product(input logic signed [63:0] x,
                                                       input logic signed [63:0] v);
    logic signed [127:0] xw;
    logic signed [127:0] vw;
    logic signed [127:0] wide;
    xw = x;
    vw = v;
    wide = xw * vw;
    return 64'(wide >>> (FRAC - 1));
  endfunction

  // Append one predicted term at the tail of the queue.
  function automatic void queue_term(input cheb_term_t term);
    pending_terms.insert(pending_terms.size(), term);
  endfunction

  // Run the recurrence for one sample position under the current max_order and
  // queue every term it yields, order 0 first.
  function automatic void expand_chebyshev_terms(input logic [POS_BITS-1:0] pos);
    logic signed [63:0] x;
    logic signed [63:0] t_prev;
    logic signed [63:0] t_cur;
    logic signed [63:0] d_prev;
    logic signed [63:0] d_cur;
    logic signed [63:0] t_new;
    logic signed [63:0] d_new;
    cheb_term_t term;
    int top;
    // x = 2u - 1 in Q1.30; the 16-bit position is exact after the shift.
    x = $signed(64'(pos) << (FRAC + 1 - POS_BITS)) - FIX_ONE;
    top = (max_order_copy > ORDER_LIMIT_V) ? int'(ORDER_LIMIT_V) : int'(max_order_copy);
    t_prev = 0;
    t_cur = FIX_ONE;
    d_prev = 0;
    d_cur = 0;
    for (int n = 0; n <= top; n++) begin
      if (n == 0) begin
        t_new = FIX_ONE;
        d_new = 0;
      end else if (n == 1) begin
        t_new = x;
        d_new = FIX_ONE;
      end else begin
        // Saturated values are the ones carried into the next order.
        t_new = clamp_range(twice_product(x, t_cur) - t_prev, BASIS_LO, BASIS_HI);
        d_new = clamp_range(2 * t_cur + twice_product(x, d_cur) - d_prev,
                            SLOPE_LO, SLOPE_HI);
      end
      t_prev = (n == 0) ? 64'sd0 : t_cur;
      d_prev = (n == 0) ? 64'sd0 : d_cur;
      t_cur = t_new;
      d_cur = d_new;
      term.order = ORDER_W'(n);
      term.value = t_new[VALUE_W-1:0];
      term.slope = d_new[SLOPE_W-1:0];
      term.last = (n == top);
      queue_term(term);
    end
  endfunction

  // Mostly uniform positions, with the endpoints, the midpoint (x = 0) and the
  // smallest step mixed in.
  function automatic logic [POS_BITS-1:0] pick_position();
    case ($urandom_range(0, 15))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h0001;
      default: return POS_BITS'($urandom());
    endcase
  endfunction

  // Offer one sample and hold it until the transfer. in_valid is left high so
  // the next call can follow back to back; a gap is opened by lowering it at
  // the first falling edge, never by lowering and raising it in one step.
  task automatic send_sample(input logic [POS_BITS-1:0] pos);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_pos <= pos;
    do @(posedge clk); while (!in_ready);
    expand_chebyshev_terms(pos);
  endtask

  // Stop offering samples and wait until every queued term has been returned.
  // Once the last result of a run has left, the block is idle again.
  task automatic drain_terms();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_terms.size() != 0) @(negedge clk);
  endtask

  // Single-cycle register write; only called with the block idle.
  task automatic set_max_order(input logic [ORDER_W-1:0] setting);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= setting;
    @(negedge clk);
    cfg_we <= 1'b0;
    max_order_copy = setting;
  endtask

  // The reset value of max_order (16) must apply before any write.
  task automatic test_reset_setting();
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h8000);
    send_sample(16'h4000);
    send_sample(16'hC001);
    drain_terms();
  endtask

  // A single term per sample, the two seed orders only, and every order up to 63
  // at x = -1, x near +1, x = 0 and a few points in between.
  task automatic test_order_extremes();
    set_max_order(6'd0);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h8000);
    drain_terms();
    set_max_order(6'd1);
    send_sample(16'h0001);
    send_sample(16'hFFFE);
    drain_terms();
    set_max_order(ORDER_LIMIT_V);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'hAAAA);
    send_sample(16'h5555);
    drain_terms();
  endtask

  // Random positions over a series of max_order settings. Most settings are
  // small to keep the run short; the first phase uses every order up to 63 and
  // the last phase a single order. Odd phases also hold the sender halfway
  // until every expected term has come back.
  task automatic test_random_sweep();
    logic [ORDER_W-1:0] setting;
    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 0) begin
        setting = ORDER_LIMIT_V;
      end else if (phase == 11) begin
        setting = '0;
      end else if ($urandom_range(0, 3) == 0) begin
        setting = ORDER_W'($urandom_range(0, 63));
      end else begin
        setting = ORDER_W'($urandom_range(1, 12));
      end
      // Phase 1 runs with no idling at all on either side.
      in_gaps_on = (phase != 1) && ($urandom_range(0, 3) != 0);
      out_stalls_on = (phase != 1) && ($urandom_range(0, 3) != 0);
      set_max_order(setting);
      for (int i = 0; i < 40; i++) begin
        send_sample(pick_position());
        if (i == 19 && phase % 2 == 1) begin
          drain_terms();
        end
      end
      drain_terms();
    end
  endtask

  // Result side: before each transfer draw a stall, then hold out_ready high
  // until a result moves.
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = out_stalls_on ? $urandom_range(0, 3) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare every result transfer with the oldest predicted term.
  always @(posedge clk) begin : check_terms
    cheb_term_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_terms.size() == 0) begin
        $display("%0t: unexpected result order %0d value %0d slope %0d last %0d, expected none",
                 $time, out_order, out_basis_value, out_basis_slope, out_last);
        mismatch_count++;
      end else begin
        want = pending_terms.pop_front();
        if (out_order !== want.order) begin
          $display("%0t: order mismatch, expected %0d, got %0d", $time, want.order, out_order);
          mismatch_count++;
        end
        if (out_basis_value !== want.value) begin
          $display("%0t: basis_value mismatch at order %0d, expected %0d, got %0d",
                   $time, want.order, want.value, out_basis_value);
          mismatch_count++;
        end
        if (out_basis_slope !== want.slope) begin
          $display("%0t: basis_slope mismatch at order %0d, expected %0d, got %0d",
                   $time, want.order, want.slope, out_basis_slope);
          mismatch_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch at order %0d, expected %0d, got %0d",
                   $time, want.order, want.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: any transfer on either channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_pos = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    max_order_copy = RESET_MAX_ORDER;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_setting();
    test_order_extremes();
    test_random_sweep();

    // Every expected term is back; watch for stray results a while longer.
    drain_terms();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_terms.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
